FILE: hw/rtl/cacd_pkg.sv
// shared types and constants for the cylindrical charge deposit block
package cacd_pkg;

    localparam int CELL_W  = 48;
    localparam int QUO_W   = 28;
    localparam int NORM_W  = 16;
    localparam int COUNT_W = 8;

    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_PICK,
        ST_MUL,
        ST_SCALE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MEM_RD,
        ST_MEM_WR,
        ST_RD_MEM,
        ST_RD_OUT
    } state_t;

endpackage

FILE: hw/rtl/cacd_div.sv
// restoring divider, one quotient bit per cycle
module cacd_div #(
    parameter int SUM_W = 40,
    parameter int DEN_W = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [SUM_W-1:0]             dividend,
    input  logic [DEN_W-1:0]             divisor,
    output logic                         done,
    output logic [cacd_pkg::QUO_W-1:0]   quotient
);

    localparam int QW  = cacd_pkg::QUO_W;
    localparam int CNW = $clog2(QW + 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [QW-1:0]    low_reg,  low_next;
    logic [CNW-1:0]   cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem2;
    logic             ge;

    always_comb
    begin
        rem2      = {rem_reg, low_reg[QW-1]};
        ge        = rem2 >= {1'b0, divisor};
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = DEN_W'(dividend >> QW);
            low_next  = dividend[QW-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(rem2 - {1'b0, divisor}) : DEN_W'(rem2);
            low_next = {low_reg[QW-2:0], ge};
            cnt_next = cnt_reg + CNW'(1);
            if (cnt_reg == CNW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

FILE: hw/rtl/cylindrical_area_charge_deposit.sv
// top level: cylindrical area-weighted charge deposit into one grid memory
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  in       | in_valid / in_stall        | opcode pos_r pos_z charge_number
//           |                            | average_count read_row read_col
//  out      | out_valid / out_stall      | cell_charge
//  cfg      | cfg_valid / cfg_ready      | normalizer
//
//  a deposit takes a setup state then up to four shares, each: pick, two
//  multiply steps, divider start, bit-serial divide, then a read and a write
//  of the grid memory; a skipped share takes only its pick; a read passes a memory
//  read and an output state that waits for the output register, then zeroes
//  the cell; after reset all 2^(clog2(rows)+clog2(cols)) cells are swept to zero
//  in_stall is high whenever the sequencer is busy; cfg is always ready
module cylindrical_area_charge_deposit #(
    parameter int RADIAL_CELLS  = 64,
    parameter int AXIAL_CELLS   = 256,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [21:0]         pos_r,
    input  logic [23:0]         pos_z,
    input  logic signed [2:0]   charge_number,
    input  logic [7:0]          average_count,
    input  logic [5:0]          read_row,
    input  logic [7:0]          read_col,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [47:0]  cell_charge,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         normalizer
);

    localparam int F     = POS_FRAC_BITS;
    localparam int WF    = F + 1;
    localparam int WW    = 2 * WF;
    localparam int NSH   = (2 * F >= 24) ? 0 : 24 - 2 * F;
    localparam int DSH   = (2 * F >= 24) ? 2 * F - 24 : 0;
    localparam int RW    = $clog2(RADIAL_CELLS);
    localparam int CW    = $clog2(AXIAL_CELLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int NUMW  = WW + 4 + NSH;
    localparam int DEN1W = cacd_pkg::NORM_W + RW + 1;
    localparam int DENW  = DEN1W + cacd_pkg::COUNT_W + DSH;
    localparam int SUMW  = ((NUMW > DENW) ? NUMW : DENW) + 1;
    localparam int CL    = cacd_pkg::CELL_W;
    localparam int QW    = cacd_pkg::QUO_W;
    localparam logic [WF-1:0] ONE  = WF'(2 ** F);
    localparam logic [WF-1:0] HALF = WF'(2 ** (F - 1));
    localparam logic signed [CL-1:0] CELL_MAX = {1'b0, {(CL - 1){1'b1}}};
    localparam logic signed [CL-1:0] CELL_MIN = {1'b1, {(CL - 1){1'b0}}};

    cacd_pkg::state_t state_reg, state_next;

    logic [15:0]              norm_reg;
    logic [AW-1:0]            clr_reg,   clr_next;
    logic [1:0]               idx_reg,   idx_next;
    logic                     out_valid_reg;
    logic signed [CL-1:0]     out_data_reg;

    logic [21:0]              pr_reg;
    logic [23:0]              pz_reg;
    logic signed [2:0]        q_reg;
    logic [7:0]               cnt_reg;
    logic [5:0]               rr_reg;
    logic [7:0]               rc_reg;

    logic [RW-1:0]            row_reg, nrow_reg;
    logic [CW-1:0]            col_reg, ncol_reg;
    logic [WF-1:0]            ksi_reg, eta_reg;
    logic                     has_r_reg, has_c_reg;
    logic [AW-1:0]            addr_reg;
    logic [WW-1:0]            w_reg;
    logic [DEN1W-1:0]         den1_reg;
    logic [NUMW-1:0]          num_reg;
    logic [DENW-1:0]          den_reg;
    logic                     rd_on_reg;

    logic [CL-1:0]            grid_mem [DEPTH];
    logic [CL-1:0]            rdata_reg;
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [CL-1:0]            mem_wdata;

    logic                     in_acc, out_free;
    logic [31:0]              row32, col32;
    logic [F-1:0]             fr, fz;
    logic [WF-1:0]            frx, fzx;
    logic                     top, right, on_grid;
    logic [3:0]               share_en;
    logic [WF-1:0]            fa, fb;
    logic [RW-1:0]            drow;
    logic [AW-1:0]            saddr;
    logic [15:0]              norm_eff;
    logic [7:0]               count_eff;
    logic [2:0]               qmag;
    logic [3:0]               qmag2;
    logic                     div_start, div_done;
    logic [SUMW-1:0]          div_sum;
    logic [QW-1:0]            quo;
    logic signed [CL:0]       acc_sum, share_s;
    logic signed [CL-1:0]     acc_sat;
    logic                     rd_on;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = state_reg != cacd_pkg::ST_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid   = out_valid_reg;
    assign cell_charge = out_data_reg;

    assign norm_eff  = (norm_reg == 16'd0) ? 16'd1 : norm_reg;
    assign count_eff = (cnt_reg == 8'd0) ? 8'd1 : cnt_reg;
    assign qmag      = q_reg[2] ? 3'(-q_reg) : 3'(q_reg);
    assign qmag2     = {qmag, 1'b0};

    // home cell and overlaps
    assign row32   = 32'(pr_reg) >> F;
    assign col32   = 32'(pz_reg) >> F;
    assign fr      = F'(pr_reg);
    assign fz      = F'(pz_reg);
    assign frx     = {1'b0, fr};
    assign fzx     = {1'b0, fz};
    assign top     = fr[F-1];
    assign right   = fz[F-1];
    assign on_grid = (row32 < 32'(RADIAL_CELLS)) && (col32 < 32'(AXIAL_CELLS));
    assign rd_on   = (32'(rr_reg) < 32'(RADIAL_CELLS)) && (32'(rc_reg) < 32'(AXIAL_CELLS));

    assign share_en = {has_r_reg, has_c_reg, has_r_reg && has_c_reg, 1'b1};

    // factors, divisor row and cell for the current share
    always_comb
    begin
        unique case (idx_reg)
            2'd0:
            begin
                fa = ONE - ksi_reg;  fb = ONE - eta_reg;
                drow = row_reg;      saddr = {row_reg, col_reg};
            end
            2'd1:
            begin
                fa = ksi_reg;        fb = eta_reg;
                drow = nrow_reg;     saddr = {nrow_reg, ncol_reg};
            end
            2'd2:
            begin
                fa = eta_reg;        fb = ONE - ksi_reg;
                drow = row_reg;      saddr = {row_reg, ncol_reg};
            end
            default:
            begin
                fa = ksi_reg;        fb = ONE - eta_reg;
                drow = nrow_reg;     saddr = {nrow_reg, col_reg};
            end
        endcase
    end

    assign div_sum   = SUMW'(num_reg) + SUMW'(den_reg >> 1);
    assign div_start = state_reg == cacd_pkg::ST_DIV_GO;

    cacd_div #(
        .SUM_W (SUMW),
        .DEN_W (DENW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_sum),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // saturating accumulate
    always_comb
    begin
        share_s = q_reg[2] ? -(CL + 1)'(quo) : (CL + 1)'(quo);
        acc_sum = {rdata_reg[CL-1], rdata_reg} + share_s;
        if (acc_sum[CL] != acc_sum[CL-1])
            acc_sat = acc_sum[CL] ? CELL_MIN : CELL_MAX;
        else
            acc_sat = acc_sum[CL-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        idx_next   = idx_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = acc_sat;
        mem_re     = 1'b0;
        mem_raddr  = addr_reg;
        unique case (state_reg)
            cacd_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = cacd_pkg::ST_IDLE;
            end
            cacd_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = (opcode == cacd_pkg::OP_READ) ? cacd_pkg::ST_RD_MEM
                                                               : cacd_pkg::ST_SETUP;
            end
            cacd_pkg::ST_SETUP:
            begin
                idx_next   = 2'd0;
                state_next = on_grid ? cacd_pkg::ST_PICK : cacd_pkg::ST_IDLE;
            end
            cacd_pkg::ST_PICK:
            begin
                if (share_en[idx_reg])
                    state_next = cacd_pkg::ST_MUL;
                else if (idx_reg == 2'd3)
                    state_next = cacd_pkg::ST_IDLE;
                else
                    idx_next = idx_reg + 2'd1;
            end
            cacd_pkg::ST_MUL:     state_next = cacd_pkg::ST_SCALE;
            cacd_pkg::ST_SCALE:   state_next = cacd_pkg::ST_DIV_GO;
            cacd_pkg::ST_DIV_GO:  state_next = cacd_pkg::ST_DIV_WAIT;
            cacd_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = cacd_pkg::ST_MEM_RD;
            end
            cacd_pkg::ST_MEM_RD:
            begin
                mem_re     = 1'b1;
                state_next = cacd_pkg::ST_MEM_WR;
            end
            cacd_pkg::ST_MEM_WR:
            begin
                mem_we = 1'b1;
                if (idx_reg == 2'd3)
                    state_next = cacd_pkg::ST_IDLE;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = cacd_pkg::ST_PICK;
                end
            end
            cacd_pkg::ST_RD_MEM:
            begin
                mem_re     = rd_on;
                mem_raddr  = {RW'(rr_reg), CW'(rc_reg)};
                state_next = cacd_pkg::ST_RD_OUT;
            end
            cacd_pkg::ST_RD_OUT:
            begin
                mem_waddr = {RW'(rr_reg), CW'(rc_reg)};
                mem_wdata = '0;
                if (out_free)
                begin
                    mem_we     = rd_on_reg;
                    state_next = cacd_pkg::ST_IDLE;
                end
            end
            default: state_next = cacd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cacd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            norm_reg      <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
                norm_reg <= normalizer;
            if (state_reg == cacd_pkg::ST_RD_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pr_reg  <= pos_r;
            pz_reg  <= pos_z;
            q_reg   <= charge_number;
            cnt_reg <= average_count;
            rr_reg  <= read_row;
            rc_reg  <= read_col;
        end
        if (state_reg == cacd_pkg::ST_SETUP)
        begin
            row_reg   <= RW'(row32);
            col_reg   <= CW'(col32);
            ksi_reg   <= top ? frx - HALF : HALF - frx;
            eta_reg   <= right ? fzx - HALF : HALF - fzx;
            nrow_reg  <= top ? RW'(row32 + 32'd1) : RW'(row32 - 32'd1);
            ncol_reg  <= right ? CW'(col32 + 32'd1) : CW'(col32 - 32'd1);
            has_r_reg <= top ? (row32 + 32'd2 < 32'(RADIAL_CELLS)) : (row32 != 32'd0);
            has_c_reg <= right ? (col32 + 32'd2 < 32'(AXIAL_CELLS)) : (col32 != 32'd0);
        end
        if (state_reg == cacd_pkg::ST_MUL)
        begin
            w_reg    <= WW'(fa) * WW'(fb);
            den1_reg <= DEN1W'(norm_eff) * DEN1W'({drow, 1'b1});
            addr_reg <= saddr;
        end
        if (state_reg == cacd_pkg::ST_SCALE)
        begin
            num_reg <= (NUMW'(w_reg) * NUMW'(qmag2)) << NSH;
            den_reg <= (DENW'(den1_reg) * DENW'(count_eff)) << DSH;
        end
        if (state_reg == cacd_pkg::ST_RD_MEM)
            rd_on_reg <= rd_on;
        if (state_reg == cacd_pkg::ST_RD_OUT && out_free)
            out_data_reg <= rd_on_reg ? rdata_reg : '0;
    end

    // grid memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= grid_mem[mem_raddr];
    end

endmodule
